[rtl/core/tli_pkg.sv]
package tli_pkg;

	localparam int unsigned DataWidth = 32;
	localparam int unsigned LenWidth  = 9;
	localparam int unsigned IdxWidth  = 8;
	localparam int unsigned StWidth   = 2;

	localparam logic       ModeWrite = 1'b0;
	localparam logic       ModeQuery = 1'b1;

	localparam logic [1:0] StatusOk    = 2'd0;
	localparam logic [1:0] StatusEmpty = 2'd1;
	localparam logic [1:0] StatusSpan  = 2'd2;

	typedef struct packed {
		logic                        mode;
		logic [IdxWidth-1:0]         entry_index;
		logic signed [DataWidth-1:0] entry_x;
		logic signed [DataWidth-1:0] entry_y;
		logic signed [DataWidth-1:0] query_x;
	} in_item_t;

	typedef struct packed {
		logic signed [DataWidth-1:0] result_y;
		logic [IdxWidth-1:0]         segment_index;
		logic [StWidth-1:0]          status;
	} out_item_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [33:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
	} div_rsp_t;

endpackage

[rtl/core/tli_stream_if.sv]
interface tli_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/core/tli_divider.sv]
module tli_divider
	import tli_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [63:0] quot_q;
	logic [34:0] rem_q;
	logic [33:0] div_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [34:0] trial;
	logic [34:0] shifted;

	assign shifted = {rem_q[33:0], quot_q[63]};
	assign trial   = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q  <= '0;
			div_q  <= req.divisor;
		end else if (busy_q) begin
			if (!trial[34]) begin
				rem_q  <= trial;
				quot_q <= {quot_q[62:0], 1'b1};
			end else begin
				rem_q  <= shifted;
				quot_q <= {quot_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quot_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.start) else $error("divider restarted while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("divider done held");
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> cnt_q == 7'd0 || cnt_q == 7'd1 || done_q || cnt_q == 7'd64)
		else $error("divider count stray");

endmodule

[rtl/core/table_linear_interpolator_unit.sv]
// Piecewise linear interpolation over a breakpoint table.
// Input channel in: one beat is a write (mode 0) or a query (mode 1).
// A write stores entry_x/entry_y at entry_index and gives no result;
// writes can follow back to back. A query gives one beat on channel
// out: result_y, segment_index and status (0 ok, 1 empty table, 2 zero or
// bad span).
// table_length is set through cfg_we/cfg_wdata; the user must do so only
// while the block is idle, as the block itself does not enforce it.
// An empty table goes straight to the output. Otherwise the first entry
// is read, then the last; a query at or beyond either is clamped to its y.
// An interpolated answer takes up to 7 search probes (reads of x[mid] and
// x[mid+1] from the single x/y memory port) plus a final compare, 16x33
// and 17x33 partial products, then a 64-step radix-2 divider. One item is
// in work at a time; the next beat can be taken once the result is loaded.
// The result sits in an output register; the next item is taken while it
// waits, and work stalls only when a second result would be due.
// Reset clears the control state and table_length; table contents are
// undefined until written. No clearing pass is needed.
module table_linear_interpolator_unit
	import tli_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	tli_stream_if.sink           in,
	tli_stream_if.source         out,
	input  logic                 cfg_we,
	input  logic [LenWidth-1:0]  cfg_wdata
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned NW = AW + 1;

	typedef enum logic [4:0] {
		S_IDLE, S_RD0, S_CHK0, S_RDN, S_CHKN, S_RDM, S_RDM1, S_CMP,
		S_RDS, S_RDS1, S_SPAN, S_MUL0, S_MUL1, S_MUL2, S_DIV, S_SUM, S_EMIT
	} state_t;

	logic [2*DataWidth-1:0] mem_q [TABLE_DEPTH];
	logic [2*DataWidth-1:0] rd_q;
	logic [AW-1:0]          rd_addr;
	logic                   rd_en;

	state_t                      state_q;
	logic [LenWidth-1:0]         len_q;
	logic signed [DataWidth-1:0] q_q;
	logic signed [NW:0]          lo_q, hi_q, mid_q;
	logic signed [DataWidth-1:0] xm_q, ym_q;
	logic signed [DataWidth:0]   dx_q, dy_q, t_q;
	logic                        neg_q;
	logic [63:0]                 prod;
	logic [48:0]                 pl_q;
	logic [49:0]                 ph_q;
	logic signed [DataWidth-1:0] y0_q;
	logic signed [DataWidth-1:0] res_q;
	logic [IdxWidth-1:0]         seg_q;
	logic [StWidth-1:0]          st_q;
	logic                        ovalid_q;
	out_item_t                   obuf_q;
	logic [NW-1:0]               n_eff;
	div_req_t                    dreq;
	div_rsp_t                    drsp;

	logic signed [DataWidth-1:0] rx, ry;
	logic [32:0]                 um, ut, udx;
	logic [63:0]                 quot;
	logic signed [DataWidth+3:0] sum;

	assign rx = rd_q[2*DataWidth-1:DataWidth];
	assign ry = rd_q[DataWidth-1:0];
	assign n_eff = (32'(len_q) > TABLE_DEPTH) ? NW'(TABLE_DEPTH) : NW'(len_q);
	assign um  = dy_q[DataWidth] ? 33'(-dy_q) : 33'(dy_q);
	assign ut  = t_q[DataWidth] ? 33'(-t_q) : 33'(t_q);
	assign udx = dx_q[DataWidth] ? 33'(-dx_q) : 33'(dx_q);
	assign quot = (drsp.quotient > 64'h4_0000_0000) ? 64'h4_0000_0000 : drsp.quotient;

	assign in.ready = (state_q == S_IDLE);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			S_RD0:  begin rd_en = 1'b1; rd_addr = '0; end
			S_RDN:  begin rd_en = 1'b1; rd_addr = AW'(n_eff - NW'(1)); end
			S_RDM:  begin rd_en = 1'b1; rd_addr = AW'(mid_q); end
			S_RDM1: begin rd_en = 1'b1; rd_addr = AW'(mid_q + 1); end
			S_RDS:  begin rd_en = 1'b1; rd_addr = AW'(lo_q); end
			S_RDS1: begin rd_en = 1'b1; rd_addr = AW'(lo_q + 1); end
			default: begin rd_en = 1'b0; rd_addr = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in.valid && in.ready && in.data.mode == ModeWrite &&
		    32'(in.data.entry_index) < TABLE_DEPTH)
			mem_q[AW'(in.data.entry_index)] <= {in.data.entry_x, in.data.entry_y};
		if (rd_en)
			rd_q <= mem_q[rd_addr];
	end

	assign prod = 64'({ph_q, 16'b0}) + 64'(pl_q);

	always_comb begin
		dreq.start    = (state_q == S_MUL2);
		dreq.dividend = prod;
		dreq.divisor  = 34'(udx);
	end

	tli_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign sum = (DataWidth+4)'(y0_q) + (neg_q ? -(DataWidth+4)'(quot) : (DataWidth+4)'(quot));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			len_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_we)
				len_q <= cfg_wdata;
			if (state_q == S_EMIT && (!ovalid_q || out.ready))
				ovalid_q <= 1'b1;
			else if (out.ready)
				ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in.valid && in.data.mode == ModeQuery) begin
						q_q <= in.data.query_x;
						if (n_eff == '0) begin
							res_q <= '0; seg_q <= '0; st_q <= StatusEmpty;
							state_q <= S_EMIT;
						end else
							state_q <= S_RD0;
					end
				end
				S_RD0: state_q <= S_CHK0;
				S_CHK0: begin
					if (q_q <= rx) begin
						res_q <= ry; seg_q <= '0; st_q <= StatusOk;
						state_q <= S_EMIT;
					end else
						state_q <= S_RDN;
				end
				S_RDN: state_q <= S_CHKN;
				S_CHKN: begin
					if (q_q >= rx) begin
						res_q <= ry; seg_q <= IdxWidth'(n_eff - NW'(1)); st_q <= StatusOk;
						state_q <= S_EMIT;
					end else begin
						lo_q <= '0;
						hi_q <= (NW+1)'(n_eff) - (NW+1)'(2);
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (lo_q == hi_q)
						state_q <= S_RDS;
					else if (lo_q > hi_q) begin
						res_q <= '0; seg_q <= '0; st_q <= StatusSpan;
						state_q <= S_EMIT;
					end else begin
						mid_q <= (lo_q + hi_q) >>> 1;
						state_q <= S_RDM;
					end
				end
				S_RDM: state_q <= S_RDM1;
				S_RDM1: begin
					xm_q <= rx;
					if (q_q < rx) begin
						hi_q <= mid_q - (NW+1)'(1);
						state_q <= S_CMP;
					end else
						state_q <= S_SPAN;
				end
				S_SPAN: begin
					if (q_q < rx) begin
						lo_q <= mid_q;
						state_q <= S_RDS;
					end else begin
						lo_q <= mid_q + (NW+1)'(1);
						state_q <= S_CMP;
					end
				end
				S_RDS: state_q <= S_RDS1;
				S_RDS1: begin
					xm_q <= rx; ym_q <= ry; y0_q <= ry;
					t_q <= (DataWidth+1)'(q_q) - (DataWidth+1)'(rx);
					state_q <= S_MUL0;
				end
				S_MUL0: begin
					dx_q <= (DataWidth+1)'(rx) - (DataWidth+1)'(xm_q);
					dy_q <= (DataWidth+1)'(ry) - (DataWidth+1)'(ym_q);
					seg_q <= IdxWidth'(lo_q);
					if (rx == xm_q) begin
						res_q <= '0; st_q <= StatusSpan;
						state_q <= S_EMIT;
					end else
						state_q <= S_MUL1;
					neg_q <= 1'b0;
				end
				S_MUL1: begin
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (drsp.done)
						state_q <= S_SUM;
				end
				S_SUM: begin
					st_q <= StatusOk;
					if (sum > (DataWidth+4)'(32'sh7fff_ffff))
						res_q <= 32'sh7fff_ffff;
					else if (sum < -(DataWidth+4)'(33'sh0_8000_0000))
						res_q <= 32'sh8000_0000;
					else
						res_q <= DataWidth'(sum);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!ovalid_q || out.ready) begin
						obuf_q   <= '{result_y: res_q, segment_index: seg_q, status: st_q};
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_MUL1) begin
				pl_q  <= 49'(um[15:0]) * 49'(ut);
				ph_q  <= 50'(um[32:16]) * 50'(ut);
				neg_q <= dy_q[DataWidth] ^ t_q[DataWidth] ^ dx_q[DataWidth];
			end
		end
	end

	assign out.valid = ovalid_q;
	assign out.data  = obuf_q;

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && ovalid_q && !out.ready) |=> state_q == S_EMIT)
		else $error("result dropped under stall");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in.ready |-> state_q == S_IDLE) else $error("accepted while busy");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> state_q == S_DIV) else $error("divider done out of place");

endmodule

[test/tb_table_linear_interpolator_unit.sv]
`timescale 1ns / 1ps

module tb_table_linear_interpolator_unit;
	import tli_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [LenWidth-1:0] cfg_wdata = '0;

	tli_stream_if #(.T(in_item_t))  in_ch ();
	tli_stream_if #(.T(out_item_t)) out_ch ();

	table_linear_interpolator_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in       (in_ch.sink),
		.out      (out_ch.source),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	in_item_t  pending_q[$];
	out_item_t expected_q[$];
	logic signed [31:0] bp_x[256];
	logic signed [31:0] bp_y[256];
	logic [LenWidth-1:0] live_length;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit holding;
	event hold_start;
	int errors = 0;

	task automatic queue_item(input in_item_t it);
		pending_q.insert(pending_q.size(), it);
	endtask

	function automatic int find_span(input int lo, input int hi, input longint q);
		int mid;
		while (1) begin
			if (lo == hi) return lo;
			if (lo > hi) return -1;
			mid = (lo + hi) / 2;
			if (longint'(bp_x[mid]) <= q && q < longint'(bp_x[mid + 1])) return mid;
			if (q < longint'(bp_x[mid])) hi = mid - 1;
			else lo = mid + 1;
		end
	endfunction

	function automatic out_item_t interpolate(input logic signed [31:0] qx);
		out_item_t r;
		int n;
		int seg;
		longint q, dx, dy, t, res;
		logic [63:0] um, ut, udx, quot;
		bit neg;
		n = (live_length > 256) ? 256 : int'(live_length);
		q = longint'(qx);
		r = '{result_y: '0, segment_index: '0, status: StatusOk};
		if (n == 0) begin
			r.status = StatusEmpty;
			return r;
		end
		if (q <= longint'(bp_x[0])) begin
			r.result_y = bp_y[0];
			return r;
		end
		if (q >= longint'(bp_x[n - 1])) begin
			r.result_y = bp_y[n - 1];
			r.segment_index = IdxWidth'(n - 1);
			return r;
		end
		seg = find_span(0, n - 2, q);
		if (seg < 0) begin
			r.status = StatusSpan;
			return r;
		end
		r.segment_index = IdxWidth'(seg);
		dx = longint'(bp_x[seg + 1]) - longint'(bp_x[seg]);
		if (dx == 0) begin
			r.status = StatusSpan;
			return r;
		end
		dy = longint'(bp_y[seg + 1]) - longint'(bp_y[seg]);
		t = q - longint'(bp_x[seg]);
		neg = (dy < 0) ^ (t < 0) ^ (dx < 0);
		um = (dy < 0) ? -dy : dy;
		ut = (t < 0) ? -t : t;
		udx = (dx < 0) ? -dx : dx;
		quot = (um * ut) / udx;
		if (quot > (64'd1 << 34)) quot = 64'd1 << 34;
		res = longint'(bp_y[seg]) + (neg ? -longint'(quot) : longint'(quot));
		if (res > 64'sd2147483647) res = 64'sd2147483647;
		if (res < -64'sd2147483648) res = -64'sd2147483648;
		r.result_y = res[31:0];
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data  <= '0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (pending_q.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
				in_ch.valid <= 1'b1;
				in_ch.data  <= pending_q.pop_front();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// predict on accepted beats
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			if (in_ch.data.mode == ModeWrite) begin
				bp_x[in_ch.data.entry_index] <= in_ch.data.entry_x;
				bp_y[in_ch.data.entry_index] <= in_ch.data.entry_y;
			end else begin
				expected_q.insert(expected_q.size(), interpolate(in_ch.data.query_x));
			end
		end
	end

	// long receiver hold-off
	initial begin
		holding <= 1'b0;
		@(hold_start);
		holding <= 1'b1;
		repeat (300) @(posedge clk);
		holding <= 1'b0;
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (holding) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected beat %h", $time, out_ch.data);
				errors++;
			end else begin
				exp_r = expected_q.pop_front();
				if (out_ch.data.result_y !== exp_r.result_y
						|| out_ch.data.segment_index !== exp_r.segment_index
						|| out_ch.data.status !== exp_r.status) begin
					$display("%0t: mismatch expected y=%h seg=%0d st=%0d actual y=%h seg=%0d st=%0d",
						$time, exp_r.result_y, exp_r.segment_index, exp_r.status,
						out_ch.data.result_y, out_ch.data.segment_index, out_ch.data.status);
					errors++;
				end
			end
		end
	end

	function automatic in_item_t wr_item(input int idx, input logic [31:0] x,
			input logic [31:0] y);
		in_item_t it;
		it = '{mode: ModeWrite, entry_index: idx[7:0], entry_x: x, entry_y: y,
			query_x: $urandom()};
		return it;
	endfunction

	function automatic in_item_t qry_item(input logic [31:0] q);
		in_item_t it;
		it = '{mode: ModeQuery, entry_index: IdxWidth'($urandom()), entry_x: $urandom(),
			entry_y: $urandom(), query_x: q};
		return it;
	endfunction

	task automatic drain();
		wait (pending_q.size() == 0);
		@(posedge clk);
		while (in_ch.valid || expected_q.size() > 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic set_length(input int n);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= LenWidth'(n);
		live_length <= LenWidth'(n);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// non-decreasing table of n entries with random steps, some of them zero
	task automatic load_table(input int n, input int step_max, input bit wild_y);
		logic signed [31:0] x;
		x = -$signed(32'(($urandom_range(step_max, 1) * n) / 2));
		for (int i = 0; i < n; i++) begin
			queue_item(wr_item(i, x, wild_y ? $urandom()
				: 32'($signed($urandom_range(200000, 0)) - 100000)));
			x = x + $urandom_range(step_max, (i % 7 == 3) ? 0 : 1);
		end
	endtask

	task automatic random_queries(input int n, input int span);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9, 0) == 0) queue_item(qry_item($urandom()));
			else queue_item(qry_item(32'($signed($urandom_range(2 * span, 0)) - span)));
		end
	endtask

	initial begin
		live_length = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 12;
		recv_idle_pct = 74;
		queue_item(qry_item(32'h8000_0000));
		queue_item(qry_item(32'h7fff_ffff));
		drain();

		set_length(4);
		queue_item(wr_item(0, 32'h8000_0000, 32'h7fff_ffff));
		queue_item(wr_item(1, 32'h0000_0000, 32'h8000_0000));
		queue_item(wr_item(2, 32'h0000_0000, 32'h0001_0000));
		queue_item(wr_item(3, 32'h7fff_ffff, 32'h8000_0000));
		queue_item(qry_item(32'h8000_0000));
		queue_item(qry_item(32'h8000_0001));
		queue_item(qry_item(32'hc000_0000));
		queue_item(qry_item(32'h0000_0000));
		queue_item(qry_item(32'h4000_0000));
		queue_item(qry_item(32'h7fff_fffe));
		queue_item(qry_item(32'h7fff_ffff));
		queue_item(wr_item(255, 32'hffff_ffff, 32'h0));
		queue_item(wr_item(2, 32'h7000_0000, 32'h7fff_ffff));
		queue_item(wr_item(1, 32'h7800_0000, 32'h8000_0000));
		queue_item(qry_item(32'h7400_0000));
		queue_item(qry_item(32'h7c00_0000));
		queue_item(qry_item(32'h0000_0000));
		drain();

		set_length(2);
		queue_item(qry_item(32'h4000_0000));
		queue_item(qry_item(32'h0000_0000));
		drain();

		set_length(256);
		load_table(256, 60000, 1'b0);
		random_queries(290, 8000000);
		drain();

		send_idle_pct = 74;
		recv_idle_pct = 12;
		set_length(1);
		random_queries(20, 8000000);
		drain();
		set_length(511);
		random_queries(60, 8000000);
		drain();

		set_length(9);
		load_table(9, 4000000, 1'b1);
		random_queries(120, 20000000);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_length(40);
		load_table(40, 3000, 1'b0);
		random_queries(10, 60000);
		-> hold_start;
		random_queries(100, 60000);
		drain();

		for (int k = 0; k < 50; k++)
			queue_item(wr_item($urandom_range(39, 0), $urandom(), $urandom()));
		random_queries(60, 60000);
		drain();
		set_length(0);
		random_queries(10, 60000);
		drain();

		if (errors == 0)
			$display("PASS table_linear_interpolator_unit");
		else
			$display("FAIL table_linear_interpolator_unit");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAIL table_linear_interpolator_unit");
		$finish;
	end
endmodule
